/* rtl/sat_pkg.sv */
// shared types and constants for the segmented address translator
// no dependencies; used by the interfaces, sat_xlate and the top level
package sat_pkg;

  // backing store and address geometry
  localparam int MemBytes  = 1024;
  localparam int MemAddrW  = $clog2(MemBytes);
  localparam int VaddrBits = 8;
  localparam int SegBits   = 2;
  localparam int OffBits   = VaddrBits - SegBits;
  localparam int SegSpan   = 1 << OffBits;

  // fixed field widths
  localparam int CmdW   = 1;
  localparam int VaW    = 8;
  localparam int ByteW  = 8;
  localparam int BaseW  = 10;
  localparam int SizeW  = 7;
  localparam int PermW  = 9;
  localparam int PhysW  = 11;
  localparam int StatW  = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;

  localparam logic [PermW-1:0] SegPermsReset = 9'd219;

  // segment select codes
  localparam logic [SegBits-1:0] SegCode  = 2'd0;
  localparam logic [SegBits-1:0] SegHeap  = 2'd1;
  localparam logic [SegBits-1:0] SegStack = 2'd2;
  // no segment behind this select value
  localparam logic [SegBits-1:0] SegBad   = 2'd3;

  // command codes
  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  typedef enum logic [StatW-1:0] {
    StOk     = 3'd0,
    StBadSeg = 3'd1,
    StProt   = 3'd2,
    StSize   = 3'd3,
    StStack  = 3'd4,
    StPhys   = 3'd5
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCodeBase  = 3'd0,
    CfgCodeSize  = 3'd1,
    CfgHeapBase  = 3'd2,
    CfgHeapSize  = 3'd3,
    CfgStackBase = 3'd4,
    CfgStackSize = 3'd5,
    CfgSegPerms  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [BaseW-1:0] code_base;
    logic [SizeW-1:0] code_size;
    logic [BaseW-1:0] heap_base;
    logic [SizeW-1:0] heap_size;
    logic [BaseW-1:0] stack_base;
    logic [SizeW-1:0] stack_size;
    logic [PermW-1:0] seg_perms;
  } cfg_t;

  // translation outcome handed to the memory stage
  typedef struct packed {
    status_t          status;
    logic [PhysW-1:0] phys;
    logic             mem_hit;
  } xlate_t;

endpackage

/* rtl/sat_req_if.sv */
// request channel: one byte read or write at a virtual address
// depends on sat_pkg
interface sat_req_if import sat_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [VaW-1:0]   vaddr;
  logic [ByteW-1:0] wdata;

  modport source (output valid, cmd, vaddr, wdata, input ready);
  modport sink   (input valid, cmd, vaddr, wdata, output ready);
endinterface

/* rtl/sat_rsp_if.sv */
// response channel: status, physical address and read byte
// depends on sat_pkg
interface sat_rsp_if import sat_pkg::*;;
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [PhysW-1:0] paddr;
  logic [ByteW-1:0] rdata;

  modport source (output valid, status, paddr, rdata, input ready);
  modport sink   (input valid, status, paddr, rdata, output ready);
endinterface

/* rtl/sat_xlate.sv */
// segment lookup, rights and size checks, physical address formation
// depends on sat_pkg
module sat_xlate import sat_pkg::*; (
  input  logic [CmdW-1:0] cmd,
  input  logic [VaW-1:0]  vaddr,
  input  cfg_t            cfg,
  output xlate_t          xl
);

  logic [SegBits-1:0] seg;
  logic [OffBits-1:0] off;
  logic [2:0]         rights;
  logic [BaseW-1:0]   base;
  logic [SizeW-1:0]   size;
  logic [OffBits-1:0] real_off;
  logic [PhysW-1:0]   phys_sum;
  logic               need_ok;

  // split the address into segment select and offset
  assign seg = vaddr[VaddrBits-1 -: SegBits];
  assign off = vaddr[OffBits-1:0];

  // per-segment registers
  always_comb begin
    case (seg)
      SegCode: begin
        rights = cfg.seg_perms[2:0];
        base   = cfg.code_base;
        size   = cfg.code_size;
      end
      SegHeap: begin
        rights = cfg.seg_perms[5:3];
        base   = cfg.heap_base;
        size   = cfg.heap_size;
      end
      SegStack: begin
        rights = cfg.seg_perms[8:6];
        base   = cfg.stack_base;
        size   = cfg.stack_size;
      end
      default: begin
        rights = '0;
        base   = '0;
        size   = '0;
      end
    endcase
  end

  assign need_ok  = (cmd == CmdWrite) ? rights[1] : rights[0];
  // stack grows down from the top of its span
  assign real_off = (seg == SegStack) ? OffBits'(SegSpan - 1) - off : off;
  assign phys_sum = PhysW'(base) + PhysW'(real_off);

  // checks in priority order
  always_comb begin
    xl.status  = StOk;
    xl.phys    = '0;
    xl.mem_hit = 1'b0;
    if (seg == SegBad) begin
      xl.status = StBadSeg;
    end else if (!need_ok) begin
      xl.status = StProt;
    end else if (SizeW'(off) >= size) begin
      xl.status = (seg == SegStack) ? StStack : StSize;
    end else begin
      xl.phys = phys_sum;
      if (phys_sum >= PhysW'(MemBytes)) begin
        xl.status = StPhys;
      end else begin
        xl.mem_hit = 1'b1;
      end
    end
  end

endmodule

/* rtl/segmented_address_translator_top.sv */
// segmented address translator: base and bounds with per-segment rights
// the result is registered and valid in the cycle after the request transaction is accepted
// throughput: one transaction per cycle while the response side takes results
// set by the single-port byte store (one read or one write per cycle)
// reset: configuration returns to defaults; a clearing pass then zeroes all
// 1024 bytes of the store, and no request is accepted until it ends
module segmented_address_translator_top import sat_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  sat_req_if.sink             req,
  sat_rsp_if.source           rsp
);

  cfg_t                cfg;
  xlate_t              xl;
  logic                accept;
  logic                clr_active;
  logic [MemAddrW-1:0] clr_addr;
  logic [ByteW-1:0]    mem [MemBytes];
  logic [ByteW-1:0]    mem_rdata;
  logic                mem_we;
  logic [MemAddrW-1:0] mem_waddr;
  logic [ByteW-1:0]    mem_wdata;
  logic                mem_re;
  logic                out_valid;
  status_t             out_status;
  logic [PhysW-1:0]    out_phys;
  logic                out_rd_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{code_base: '0, code_size: '0, heap_base: '0, heap_size: '0,
               stack_base: '0, stack_size: '0, seg_perms: SegPermsReset};
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CfgCodeBase:  cfg.code_base  <= cfg_wdata[BaseW-1:0];
        CfgCodeSize:  cfg.code_size  <= cfg_wdata[SizeW-1:0];
        CfgHeapBase:  cfg.heap_base  <= cfg_wdata[BaseW-1:0];
        CfgHeapSize:  cfg.heap_size  <= cfg_wdata[SizeW-1:0];
        CfgStackBase: cfg.stack_base <= cfg_wdata[BaseW-1:0];
        CfgStackSize: cfg.stack_size <= cfg_wdata[SizeW-1:0];
        CfgSegPerms:  cfg.seg_perms  <= cfg_wdata[PermW-1:0];
        default: ;
      endcase
    end
  end

  sat_xlate u_xlate (
    .cmd   (req.cmd),
    .vaddr (req.vaddr),
    .cfg   (cfg),
    .xl    (xl)
  );

  // handshake: take a request when not clearing and the output slot is free or draining
  assign req.ready = !clr_active && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + MemAddrW'(1);
      if (clr_addr == MemAddrW'(MemBytes - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // memory port selection
  assign mem_we    = clr_active || (accept && xl.mem_hit && req.cmd == CmdWrite);
  assign mem_waddr = clr_active ? clr_addr : xl.phys[MemAddrW-1:0];
  assign mem_wdata = clr_active ? '0 : req.wdata;
  assign mem_re    = accept && xl.mem_hit && req.cmd == CmdRead;

  // byte store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[xl.phys[MemAddrW-1:0]];
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= xl.status;
      out_phys   <= xl.phys;
      out_rd_ok  <= mem_re;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.paddr  = out_phys;
  assign rsp.rdata  = out_rd_ok ? mem_rdata : '0;

endmodule

/* bench/segmented_address_translator_checker.sv */
// response checker for the segmented address translator: tracks the segment
// layout and a byte image, predicts each reply and compares it with the block
// depends on sat_pkg, sat_req_if and sat_rsp_if
module segmented_address_translator_checker import sat_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  sat_req_if                  req,
  sat_rsp_if                  rsp,
  output int                  mismatches,
  output int                  outstanding,
  output int                  compared
);

  typedef struct packed {
    status_t          status;
    logic [PhysW-1:0] phys;
    logic [ByteW-1:0] rdata;
  } reply_t;

  // segment layout as last written, plus the image of the byte store
  logic [BaseW-1:0] seg_base [3];
  logic [SizeW-1:0] seg_size [3];
  logic [PermW-1:0] seg_perms;
  logic [ByteW-1:0] mem_image [MemBytes];

  reply_t expected_replies[$];

  // translate one access and apply it to the byte image
  function automatic reply_t translate_access(input logic [CmdW-1:0] cmd,
                                              input logic [VaW-1:0] va,
                                              input logic [ByteW-1:0] wd);
    reply_t r;
    logic [SegBits-1:0] seg;
    logic [2:0] rights;
    int off;
    int where;
    r.status = StOk;
    r.phys = '0;
    r.rdata = '0;
    seg = va[VaddrBits-1 -: SegBits];
    off = int'(va[OffBits-1:0]);
    if (seg > SegStack) begin
      r.status = StBadSeg;
    end else begin
      rights = seg_perms[3*seg +: 3];
      if ((cmd == CmdWrite) ? !rights[1] : !rights[0]) begin
        r.status = StProt;
      end else if (off >= int'(seg_size[seg])) begin
        r.status = (seg == SegStack) ? StStack : StSize;
      end else begin
        // stack grows down from the top of its span
        where = int'(seg_base[seg]) + ((seg == SegStack) ? SegSpan - off - 1 : off);
        r.phys = where[PhysW-1:0];
        if (where >= MemBytes) begin
          r.status = StPhys;
        end else if (cmd == CmdWrite) begin
          mem_image[where] = wd;
        end else begin
          r.rdata = mem_image[where];
        end
      end
    end
    return r;
  endfunction

  // register writes, reply comparison, then new request transactions
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        seg_base[k] = '0;
        seg_size[k] = '0;
      end
      seg_perms = SegPermsReset;
      for (int a = 0; a < MemBytes; a++) mem_image[a] = '0;
      expected_replies.delete();
      mismatches = 0;
      compared = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgCodeBase:  seg_base[SegCode]  = cfg_wdata[BaseW-1:0];
          CfgCodeSize:  seg_size[SegCode]  = cfg_wdata[SizeW-1:0];
          CfgHeapBase:  seg_base[SegHeap]  = cfg_wdata[BaseW-1:0];
          CfgHeapSize:  seg_size[SegHeap]  = cfg_wdata[SizeW-1:0];
          CfgStackBase: seg_base[SegStack] = cfg_wdata[BaseW-1:0];
          CfgStackSize: seg_size[SegStack] = cfg_wdata[SizeW-1:0];
          CfgSegPerms:  seg_perms          = cfg_wdata[PermW-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_replies.size() == 0) begin
          $error("reply transaction with no request outstanding");
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          compared++;
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            mismatches++;
          end
          if (rsp.paddr !== want.phys) begin
            $error("paddr: expected %0d, got %0d", want.phys, rsp.paddr);
            mismatches++;
          end
          if (rsp.rdata !== want.rdata) begin
            $error("rdata: expected %0d, got %0d", want.rdata, rsp.rdata);
            mismatches++;
          end
        end
      end
      if (req.valid && req.ready)
        expected_replies.push_back(translate_access(req.cmd, req.vaddr, req.wdata));
    end
    outstanding = expected_replies.size();
  end

  // leftover expectations at the end are reported by the top through outstanding

endmodule

/* bench/segmented_address_translator_top_test.sv */
// test top for the segmented address translator: clock, reset, register
// writes and access stimulus, with the checker instantiated beside the block
// depends on sat_pkg, both channel interfaces, the block and the checker
module segmented_address_translator_top_test;
  import sat_pkg::*;

  // index past the end of the register list, written to see it ignored
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  // common register values
  localparam logic [CfgDataW-1:0] FullSize     = CfgDataW'(SegSpan);
  localparam logic [CfgDataW-1:0] TopByte      = CfgDataW'(MemBytes - 1);
  localparam logic [CfgDataW-1:0] PermsDefault = CfgDataW'(SegPermsReset);

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  int mismatches;
  int outstanding;
  int compared;
  int send_idle_pct;
  int recv_idle_pct;
  int accesses_sent;
  int layouts_applied;

  sat_req_if req_ch ();
  sat_rsp_if rsp_ch ();

  segmented_address_translator_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  segmented_address_translator_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared)
  );

  always #5 clk = ~clk;

  // response side stalls at random
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // hold requests off until every reply is back, then let the pipe empty
  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  // one register write; the caller drops the write enable afterwards
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_layout(input logic [CfgDataW-1:0] cb, input logic [CfgDataW-1:0] cs,
                              input logic [CfgDataW-1:0] hb, input logic [CfgDataW-1:0] hs,
                              input logic [CfgDataW-1:0] sb, input logic [CfgDataW-1:0] ss,
                              input logic [CfgDataW-1:0] perms);
    settle();
    write_reg(CfgCodeBase, cb);
    write_reg(CfgCodeSize, cs);
    write_reg(CfgHeapBase, hb);
    write_reg(CfgHeapSize, hs);
    write_reg(CfgStackBase, sb);
    write_reg(CfgStackSize, ss);
    write_reg(CfgSegPerms, perms);
    write_reg(CfgUnused, CfgDataW'($urandom_range(1023)));
    cfg_we <= 1'b0;
    layouts_applied++;
  endtask

  // one request transaction, with random idle cycles ahead of it
  task automatic send_access(input logic [CmdW-1:0] cmd, input logic [VaW-1:0] va,
                             input logic [ByteW-1:0] wd);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= cmd;
    req_ch.vaddr <= va;
    req_ch.wdata <= wd;
    do @(posedge clk); while (!req_ch.ready);
    accesses_sent++;
  endtask

  // bases: mostly where a full segment fits, sometimes at the very ends
  function automatic logic [CfgDataW-1:0] pick_base();
    case ($urandom_range(9))
      0: return '0;
      1: return TopByte;
      2, 3: return CfgDataW'($urandom_range(MemBytes - 1));
      default: return CfgDataW'($urandom_range(MemBytes - SegSpan));
    endcase
  endfunction

  // sizes: half the time the full span, some short, some past it, stray high bits now and then
  function automatic logic [CfgDataW-1:0] pick_size();
    logic [CfgDataW-1:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1, 2: v = CfgDataW'($urandom_range(SegSpan));
      3, 4: v = CfgDataW'($urandom_range(127, SegSpan + 1));
      default: v = FullSize;
    endcase
    if ($urandom_range(3) == 0) v[CfgDataW-1:SizeW] = 3'($urandom_range(7));
    return v;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_perms();
    logic [CfgDataW-1:0] v;
    case ($urandom_range(9))
      0, 1: v = PermsDefault;
      2, 3, 4, 5: v = 10'h1FF;
      default: v = CfgDataW'($urandom_range(511));
    endcase
    if ($urandom_range(3) == 0) v[CfgDataW-1] = 1'b1;
    return v;
  endfunction

  // mostly valid segments, some accesses to the missing fourth one
  function automatic logic [VaW-1:0] pick_vaddr();
    logic [SegBits-1:0] seg;
    seg = ($urandom_range(9) == 0) ? SegBad : SegBits'($urandom_range(SegStack));
    return {seg, OffBits'($urandom_range(SegSpan - 1))};
  endfunction

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.cmd <= CmdRead;
    req_ch.vaddr <= '0;
    req_ch.wdata <= '0;
    send_idle_pct = 34;
    recv_idle_pct = 73;
    accesses_sent = 0;
    layouts_applied = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset layout: every size is zero
    send_access(CmdRead, 8'h00, 8'h00);
    send_access(CmdWrite, 8'hC0, 8'hFF);

    // full segments, heap at the top of memory, stack based at byte 100
    apply_layout('0, FullSize, TopByte, FullSize, 10'd100, FullSize, PermsDefault);
    send_access(CmdWrite, 8'h00, 8'hFF);
    send_access(CmdRead, 8'h00, 8'h00);
    send_access(CmdWrite, 8'h3F, 8'h00);
    send_access(CmdRead, 8'h3F, 8'hFF);
    send_access(CmdWrite, 8'h40, 8'hAA);
    send_access(CmdRead, 8'h40, 8'h00);
    send_access(CmdWrite, 8'h41, 8'h55);
    send_access(CmdWrite, 8'h80, 8'h5A);
    send_access(CmdRead, 8'h80, 8'h00);
    send_access(CmdRead, 8'hBF, 8'h00);
    send_access(CmdRead, 8'hFF, 8'h00);

    // code no rights, heap read only and oversized, short write-only stack
    apply_layout('0, '0, 10'd512, 10'd127, 10'd900, 10'd10, 10'd136);
    send_access(CmdRead, 8'h00, 8'h00);
    send_access(CmdWrite, 8'h00, 8'h11);
    send_access(CmdRead, 8'h7F, 8'h00);
    send_access(CmdWrite, 8'h7F, 8'h22);
    send_access(CmdWrite, 8'h89, 8'h33);
    send_access(CmdWrite, 8'h8A, 8'h44);
    send_access(CmdRead, 8'h80, 8'h00);
    send_access(CmdWrite, 8'hC5, 8'h66);

    // random accesses under a series of layouts
    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 34;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 0)
        apply_layout('0, FullSize, '0, FullSize, '0, FullSize, 10'h1FF);
      else if (p == 4)
        apply_layout(TopByte, 10'd127, TopByte, 10'd127, TopByte, 10'd127, 10'h1FF);
      else
        apply_layout(pick_base(), pick_size(), pick_base(), pick_size(),
                     pick_base(), pick_size(), pick_perms());
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(149) == 0) settle();
        send_access(CmdW'($urandom_range(1)), pick_vaddr(), ByteW'($urandom_range(255)));
      end
    end

    settle();
    $display("covered %0d accesses under %0d segment layouts, %0d replies compared",
             accesses_sent, layouts_applied, compared);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sat_pkg.sv
rtl/sat_req_if.sv
rtl/sat_rsp_if.sv
rtl/sat_xlate.sv
rtl/segmented_address_translator_top.sv
bench/segmented_address_translator_checker.sv
bench/segmented_address_translator_top_test.sv
